/* rtl/sorted_priority_queue_with_key_match_macros.svh */
// Assertion macros for the sorted priority queue RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_WITH_KEY_MATCH_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_WITH_KEY_MATCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Package for the sorted priority queue: sizes, op and status codes, types.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int QueueDepth = 16;
    localparam int CoordBits  = 8;
    localparam int IdxBits    = $clog2(QueueDepth);
    localparam int CntBits    = $clog2(QueueDepth + 1);
    localparam int PriBits    = 16;
    localparam int HandleBits = 10;
    localparam int OpBits     = 3;
    localparam int StatusBits = 2;

    localparam logic [OpBits-1:0] OP_INSERT = 3'd0;
    localparam logic [OpBits-1:0] OP_PUSH   = 3'd1;
    localparam logic [OpBits-1:0] OP_POP    = 3'd2;
    localparam logic [OpBits-1:0] OP_FIND   = 3'd3;
    localparam logic [OpBits-1:0] OP_REMOVE = 3'd4;

    localparam logic [StatusBits-1:0] ST_OK        = 2'd0;
    localparam logic [StatusBits-1:0] ST_FULL      = 2'd1;
    localparam logic [StatusBits-1:0] ST_EMPTY     = 2'd2;
    localparam logic [StatusBits-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [CoordBits-1:0]  x;
        logic [CoordBits-1:0]  y;
        logic [PriBits-1:0]    pri;
        logic [HandleBits-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic load_req;
        logic idx_inc;
        logic exec;
    } spq_cmd_t;

    typedef struct packed {
        logic scan_stop;
        logic out_free;
    } spq_sts_t;

endpackage

`default_nettype wire

/* rtl/spq_ctrl.sv */
// Controller FSM for the sorted priority queue: accept, scan, execute.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire spq_pkg::spq_sts_t sts,
    output spq_pkg::spq_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_stop)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/spq_datapath.sv */
// Datapath for the sorted priority queue: entry registers, scan index,
// request and result registers. Depends on spq_pkg and the macros header.
`default_nettype none
`include "sorted_priority_queue_with_key_match_macros.svh"

module spq_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spq_pkg::spq_cmd_t cmd,
    output spq_pkg::spq_sts_t      sts,
    input  wire logic [47:0]       s_tdata,
    input  wire logic [2:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,
    output logic [1:0]             m_tuser
);

    spq_pkg::entry_t entry_reg [spq_pkg::QueueDepth];

    logic [spq_pkg::OpBits-1:0]     req_op_reg;
    logic [spq_pkg::CoordBits-1:0]  req_x_reg;
    logic [spq_pkg::CoordBits-1:0]  req_y_reg;
    logic [spq_pkg::PriBits-1:0]    req_pri_reg;
    logic [spq_pkg::HandleBits-1:0] req_handle_reg;

    logic [spq_pkg::CntBits-1:0] idx_reg;
    logic [spq_pkg::CntBits-1:0] idx_next;
    logic [spq_pkg::CntBits-1:0] count_reg;
    logic [spq_pkg::CntBits-1:0] count_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [47:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic [15:0] in_x16;
    logic [15:0] in_y16;

    spq_pkg::entry_t cur;
    spq_pkg::entry_t new_entry;
    spq_pkg::entry_t rep_entry;
    logic            in_range;
    logic            is_insert;
    logic            is_match;
    logic            full;
    logic            do_ins;
    logic            do_rem;
    logic            do_rep;
    logic [spq_pkg::StatusBits-1:0] status;
    logic [15:0]     rep_x16;
    logic [15:0]     rep_y16;
    logic [15:0]     occ16;

    assign in_x16 = {8'h00, s_tdata[7:0]};
    assign in_y16 = {8'h00, s_tdata[15:8]};

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_op_reg     <= s_tuser;
            req_x_reg      <= in_x16[spq_pkg::CoordBits-1:0];
            req_y_reg      <= in_y16[spq_pkg::CoordBits-1:0];
            req_pri_reg    <= s_tdata[31:16];
            req_handle_reg <= s_tdata[41:32];
        end
    end

    // scan compare
    assign cur       = entry_reg[idx_reg[spq_pkg::IdxBits-1:0]];
    assign in_range  = idx_reg < count_reg;
    assign is_insert = req_op_reg == spq_pkg::OP_INSERT;
    assign is_match  = (req_op_reg == spq_pkg::OP_FIND) || (req_op_reg == spq_pkg::OP_REMOVE);
    assign full      = count_reg == spq_pkg::CntBits'(spq_pkg::QueueDepth);

    always_comb
    begin
        sts.scan_stop = !in_range
                        || !(is_insert || is_match)
                        || (is_insert && (cur.pri > req_pri_reg))
                        || (is_match && (cur.x == req_x_reg) && (cur.y == req_y_reg));
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // execute decode
    always_comb
    begin
        status           = spq_pkg::ST_OK;
        do_ins           = 1'b0;
        do_rem           = 1'b0;
        do_rep           = 1'b0;
        new_entry.x      = req_x_reg;
        new_entry.y      = req_y_reg;
        new_entry.pri    = req_pri_reg;
        new_entry.handle = req_handle_reg;
        unique case (req_op_reg)
            spq_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status = spq_pkg::ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            spq_pkg::OP_PUSH:
            begin
                new_entry.pri = '0;
                if (full)
                begin
                    status = spq_pkg::ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            spq_pkg::OP_POP:
            begin
                if (!in_range)
                begin
                    status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    do_rep = 1'b1;
                    do_rem = 1'b1;
                end
            end
            spq_pkg::OP_FIND:
            begin
                if (!in_range)
                begin
                    status = spq_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    do_rep = 1'b1;
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                if (!in_range)
                begin
                    status = spq_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    do_rep = 1'b1;
                    do_rem = 1'b1;
                end
            end
            default:
            begin
                status = spq_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.exec && do_rem)
        begin
            count_next = count_reg - 1'b1;
        end

        idx_next = idx_reg;
        if (cmd.load_req)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // entry shift on insert or removal at the scan position
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_ins)
        begin
            for (int i = 1; i < spq_pkg::QueueDepth; i++)
            begin
                if (spq_pkg::CntBits'(i) > idx_reg)
                begin
                    entry_reg[i] <= entry_reg[i-1];
                end
            end
            for (int i = 0; i < spq_pkg::QueueDepth; i++)
            begin
                if (spq_pkg::CntBits'(i) == idx_reg)
                begin
                    entry_reg[i] <= new_entry;
                end
            end
        end
        else if (cmd.exec && do_rem)
        begin
            for (int i = 0; i < spq_pkg::QueueDepth - 1; i++)
            begin
                if (spq_pkg::CntBits'(i) >= idx_reg)
                begin
                    entry_reg[i] <= entry_reg[i+1];
                end
            end
        end
    end

    // result register
    assign rep_entry = do_rep ? cur : '0;
    assign rep_x16   = 16'(rep_entry.x);
    assign rep_y16   = 16'(rep_entry.y);
    assign occ16     = 16'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_user_reg <= status;
            out_data_reg <= {1'b0, occ16[4:0], rep_entry.handle, rep_entry.pri,
                             rep_y16[7:0], rep_x16[7:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `SPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= spq_pkg::CntBits'(spq_pkg::QueueDepth), "count above depth")
    `SPQ_ASSERT_NOW(a_idx_bound, clk, rst_n, 1'b1,
        idx_reg <= count_reg, "scan index past count")
    `SPQ_ASSERT_NEXT(a_exec_shows, clk, rst_n, cmd.exec,
        m_tvalid && (m_tdata[46:42] == 5'(count_reg)), "result not posted")

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue_with_key_match.sv */
// Operation: after a request is accepted the scan examines one entry per cycle
// until it stops, then the execute state writes the result register once the
// result side is free; a stalled result side holds the queue in execute.
// Requests are not overlapped: s_tready is high only in idle, and the single
// shared compare walks the entry registers for each request.
// Reset: rst_n async active low empties the queue and drops any pending result.
`default_nettype none

module sorted_priority_queue_with_key_match (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // cell_x, cell_y, priority_req, node_handle, pad
    input  wire logic [2:0]  s_tuser,  // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // out_x, out_y, out_priority, out_handle, occupancy, pad
    output logic [1:0]       m_tuser   // status
);

    spq_pkg::spq_cmd_t cmd;
    spq_pkg::spq_sts_t sts;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
